// File: design/tpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_pkg
// Shared types and constants of the threshold peak picker.
// ----------------------------------------------------------------------------
package tpp_pkg;

	localparam int SAMPLE_W   = 16;
	localparam int CFG_DATA_W = 16;
	localparam int CFG_IDX_W  = 1;
	localparam int MIN_DIST_W = 6;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST  = 1'd1;

	localparam logic [CFG_DATA_W-1:0] THRESHOLD_RESET = 16'd22938;

	typedef enum logic [1:0] {
		ST_LOAD  = 2'b01,
		ST_DRAIN = 2'b10
	} state_t;

	// broadcast control of the cell row
	typedef struct packed {
		logic insert;
		logic shift;
		logic clear;
		logic head_keep;
	} cell_ctrl_t;

endpackage

`default_nettype wire

// File: design/tpp_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_in_if
// Sample channel: one signed sample and the end-of-window mark per beat.
// ----------------------------------------------------------------------------
interface tpp_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample;
	logic               last_sample;

	modport source (output valid, output sample, output last_sample, input ready);
	modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

`default_nettype wire

// File: design/tpp_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_out_if
// Peak channel: one kept peak index, or the empty-window mark, per beat.
// ----------------------------------------------------------------------------
interface tpp_out_if #(
	parameter int IDX_W = 6
);
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] peak_index;
	logic             peak_valid;
	logic             last_peak;

	modport source (output valid, output peak_index, output peak_valid, output last_peak,
		input ready);
	modport sink   (input valid, input peak_index, input peak_valid, input last_peak,
		output ready);
endinterface

`default_nettype wire

// File: design/threshold_peak_picker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// threshold_peak_picker
// Local-maximum peak picker with threshold and minimum peak distance.
// ----------------------------------------------------------------------------
// Samples load at one beat per cycle while in ST_LOAD; each local maximum
// is dropped into a row of MAX_CANDIDATES cells that keeps them sorted by
// value, largest first, ties in sample order. After the beat with last_sample
// the row drains one cell per cycle from its head while the output is not
// stalled: a head above threshold and not too close to a peak already kept
// goes out, and every cell checks its own distance to it. The drain examines
// at least one and at most all of the candidates. The next window is taken
// in the cycle after a window's final beat is loaded into the output register.
// ----------------------------------------------------------------------------
module threshold_peak_picker #(
	parameter int MAX_WINDOW     = 64,
	parameter int MAX_CANDIDATES = 33
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	tpp_in_if.sink                                 in_ch,
	tpp_out_if.source                              out_ch,
	input  wire                                    cfg_we,
	input  wire logic [tpp_pkg::CFG_IDX_W-1:0]     cfg_idx,
	input  wire logic [tpp_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import tpp_pkg::*;

	localparam int PW = $clog2(MAX_WINDOW);
	localparam int N  = MAX_CANDIDATES;

	state_t                  state_q;
	logic [CFG_DATA_W-1:0]   thr_q;
	logic [MIN_DIST_W-1:0]   mpd_q;

	logic                    out_valid_q;
	logic [PW-1:0]           out_pos_q;
	logic                    out_pvalid_q;
	logic                    out_last_q;

	logic                    accept;
	logic                    cand_valid;
	logic signed [SAMPLE_W-1:0] cand_value;
	logic [PW-1:0]           cand_pos;

	cell_ctrl_t              ctrl;
	logic                    step;
	logic                    head_keep;
	logic                    more;
	logic                    emit;

	logic                       c_after [N+1];
	logic                       c_valid [N+2];
	logic signed [SAMPLE_W-1:0] c_value [N+2];
	logic [PW-1:0]              c_pos   [N+2];
	logic                       c_fwd   [N+2];
	logic [N-1:0]               c_keep;
	logic [N-1:0]               c_remain;

	assign accept       = in_ch.valid && in_ch.ready;
	assign in_ch.ready  = (state_q == ST_LOAD);

	tpp_front #(
		.MAX_WINDOW     (MAX_WINDOW),
		.MAX_CANDIDATES (MAX_CANDIDATES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.sample      (in_ch.sample),
		.last_sample (in_ch.last_sample),
		.cand_valid  (cand_valid),
		.cand_value  (cand_value),
		.cand_pos    (cand_pos)
	);

	// row boundaries
	assign c_after[0]   = 1'b1;
	assign c_valid[0]   = 1'b0;
	assign c_value[0]   = '0;
	assign c_pos[0]     = '0;
	assign c_fwd[0]     = 1'b0;
	assign c_valid[N+1] = 1'b0;
	assign c_value[N+1] = '0;
	assign c_pos[N+1]   = '0;
	assign c_fwd[N+1]   = 1'b0;

	for (genvar i = 0; i < N; i++) begin : g_cell
		tpp_cell #(
			.PW (PW)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.ins_value   (cand_value),
			.ins_pos     (cand_pos),
			.head_pos    (c_pos[1]),
			.thr         (thr_q),
			.min_dist    (mpd_q),
			.prv_after   (c_after[i]),
			.prv_valid   (c_valid[i]),
			.prv_value   (c_value[i]),
			.prv_pos     (c_pos[i]),
			.nxt_valid   (c_valid[i+2]),
			.nxt_value   (c_value[i+2]),
			.nxt_pos     (c_pos[i+2]),
			.nxt_blocked (c_fwd[i+2]),
			.valid       (c_valid[i+1]),
			.value       (c_value[i+1]),
			.pos         (c_pos[i+1]),
			.after       (c_after[i+1]),
			.fwd_blocked (c_fwd[i+1]),
			.keep_ok     (c_keep[i]),
			.remain      (c_remain[i])
		);
	end

	always_comb begin
		step      = (state_q == ST_DRAIN) && (!out_valid_q || out_ch.ready);
		head_keep = step && c_keep[0];
		more      = |(c_remain & ~N'(1));
		emit      = step && (c_keep[0] || !more);
		ctrl.insert    = cand_valid;
		ctrl.head_keep = head_keep;
		ctrl.clear     = emit && !more;
		ctrl.shift     = step && more;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			case (state_q)
				ST_LOAD: begin
					if (accept && in_ch.last_sample) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (emit && !more) begin
						state_q <= ST_LOAD;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THRESHOLD_RESET;
			mpd_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_THRESHOLD: thr_q <= cfg_data;
				REG_MIN_DIST:  mpd_q <= cfg_data[MIN_DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_pos_q    <= c_keep[0] ? c_pos[1] : '0;
			out_pvalid_q <= c_keep[0];
			out_last_q   <= !more;
		end
	end

	assign out_ch.valid      = out_valid_q;
	assign out_ch.peak_index = out_pos_q;
	assign out_ch.peak_valid = out_pvalid_q;
	assign out_ch.last_peak  = out_last_q;

endmodule

`default_nettype wire

// File: design/tpp_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_front
// Window tracker: keeps the last two samples and flags local maxima.
// ----------------------------------------------------------------------------
module tpp_front #(
	parameter int MAX_WINDOW     = 64,
	parameter int MAX_CANDIDATES = 33
) (
	input  wire                                    clk,
	input  wire                                    arst_n,
	input  wire                                    accept,
	input  wire logic signed [tpp_pkg::SAMPLE_W-1:0] sample,
	input  wire                                    last_sample,
	output logic                                   cand_valid,
	output logic signed [tpp_pkg::SAMPLE_W-1:0]    cand_value,
	output logic [$clog2(MAX_WINDOW)-1:0]          cand_pos
);
	import tpp_pkg::*;

	localparam int PW   = $clog2(MAX_WINDOW);
	localparam int CNTW = $clog2(MAX_WINDOW + 1);
	localparam int CCW  = $clog2(MAX_CANDIDATES + 1);

	logic [CNTW-1:0]            count_q;
	logic signed [SAMPLE_W-1:0] prev_q;
	logic signed [SAMPLE_W-1:0] bprev_q;
	logic [CCW-1:0]             ccount_q;

	logic                       upd;
	logic                       step_c;
	logic                       fin_c;
	logic                       room;
	logic signed [SAMPLE_W-1:0] prev_n;
	logic signed [SAMPLE_W-1:0] bprev_n;
	logic [PW-1:0]              fin_pos;

	always_comb begin
		upd     = count_q < CNTW'(MAX_WINDOW);
		prev_n  = upd ? sample : prev_q;
		bprev_n = upd ? prev_q : bprev_q;
		step_c  = 1'b0;
		if (upd && count_q == CNTW'(1)) begin
			step_c = sample < prev_q;
		end else if (upd && count_q >= CNTW'(2)) begin
			step_c = (prev_q >= bprev_q) && (sample < prev_q);
		end
		fin_c   = last_sample && (count_q + CNTW'(upd) >= CNTW'(2)) && (prev_n > bprev_n);
		fin_pos = upd ? PW'(count_q) : PW'(count_q - CNTW'(1));
		room    = ccount_q < CCW'(MAX_CANDIDATES);
	end

	assign cand_valid = accept && room && (step_c || fin_c);
	assign cand_value = step_c ? prev_q : prev_n;
	assign cand_pos   = step_c ? PW'(count_q - CNTW'(1)) : fin_pos;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			prev_q   <= '0;
			bprev_q  <= '0;
			ccount_q <= '0;
		end else if (accept) begin
			if (last_sample) begin
				count_q  <= '0;
				prev_q   <= '0;
				bprev_q  <= '0;
				ccount_q <= '0;
			end else begin
				if (upd) begin
					count_q <= count_q + CNTW'(1);
					prev_q  <= sample;
					bprev_q <= prev_q;
				end
				if (cand_valid) begin
					ccount_q <= ccount_q + CCW'(1);
				end
			end
		end
	end

endmodule

`default_nettype wire

// File: design/tpp_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_cell
// One slot of the sorted candidate row: insert-shift right, drain-shift left.
// ----------------------------------------------------------------------------
module tpp_cell #(
	parameter int PW = 6
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire tpp_pkg::cell_ctrl_t                 ctrl,
	input  wire logic signed [tpp_pkg::SAMPLE_W-1:0] ins_value,
	input  wire logic [PW-1:0]                       ins_pos,
	input  wire logic [PW-1:0]                       head_pos,
	input  wire logic [tpp_pkg::CFG_DATA_W-1:0]      thr,
	input  wire logic [tpp_pkg::MIN_DIST_W-1:0]      min_dist,
	input  wire                                      prv_after,
	input  wire                                      prv_valid,
	input  wire logic signed [tpp_pkg::SAMPLE_W-1:0] prv_value,
	input  wire logic [PW-1:0]                       prv_pos,
	input  wire                                      nxt_valid,
	input  wire logic signed [tpp_pkg::SAMPLE_W-1:0] nxt_value,
	input  wire logic [PW-1:0]                       nxt_pos,
	input  wire                                      nxt_blocked,
	output logic                                     valid,
	output logic signed [tpp_pkg::SAMPLE_W-1:0]      value,
	output logic [PW-1:0]                            pos,
	output logic                                     after,
	output logic                                     fwd_blocked,
	output logic                                     keep_ok,
	output logic                                     remain
);
	import tpp_pkg::*;

	localparam int DW = PW + MIN_DIST_W;

	logic                       valid_q;
	logic signed [SAMPLE_W-1:0] value_q;
	logic [PW-1:0]              pos_q;
	logic                       blocked_q;

	logic          live;
	logic          conflict;
	logic [PW-1:0] sep;

	always_comb begin
		live     = valid_q && ($signed({value_q[SAMPLE_W-1], value_q}) >
			$signed({1'b0, thr}));
		sep      = (pos_q >= head_pos) ? pos_q - head_pos : head_pos - pos_q;
		conflict = ctrl.head_keep && (DW'(sep) <= DW'(min_dist));
	end

	assign valid       = valid_q;
	assign value       = value_q;
	assign pos         = pos_q;
	assign after       = valid_q && (value_q >= ins_value);
	assign fwd_blocked = blocked_q || conflict;
	assign keep_ok     = live && !blocked_q;
	assign remain      = keep_ok && !conflict;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			blocked_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q   <= 1'b0;
			blocked_q <= 1'b0;
		end else if (ctrl.insert) begin
			blocked_q <= 1'b0;
			if (!after && prv_after) begin
				valid_q <= 1'b1;
			end else if (!after) begin
				valid_q <= prv_valid;
			end
		end else if (ctrl.shift) begin
			valid_q   <= nxt_valid;
			blocked_q <= nxt_blocked;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.insert && !after) begin
			if (prv_after) begin
				value_q <= ins_value;
				pos_q   <= ins_pos;
			end else begin
				value_q <= prv_value;
				pos_q   <= prv_pos;
			end
		end else if (ctrl.shift) begin
			value_q <= nxt_value;
			pos_q   <= nxt_pos;
		end
	end

endmodule

`default_nettype wire

// File: design/tpp_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tpp_checker
// Port-level checks of the peak picker, bound to the top level.
// ----------------------------------------------------------------------------
module tpp_checker (
	input wire clk,
	input wire arst_n,
	input wire in_valid,
	input wire in_ready,
	input wire in_last,
	input wire out_valid,
	input wire out_ready,
	input wire out_pvalid,
	input wire out_last
);

	// empty-window beat is always the closing beat
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_pvalid || out_last))
		else $error("empty result without last_peak");

	a_last_stops_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && in_last) |=> !in_ready)
		else $error("input taken during peak search");

	a_mid_window_open: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !in_last) |=> in_ready)
		else $error("input stalled inside a window");

	a_no_input_mid_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_last) |-> !in_ready)
		else $error("input open while results of a window remain");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid)
		else $error("output beat dropped while stalled");

endmodule

bind threshold_peak_picker tpp_checker u_tpp_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_ch.valid),
	.in_ready   (in_ch.ready),
	.in_last    (in_ch.last_sample),
	.out_valid  (out_ch.valid),
	.out_ready  (out_ch.ready),
	.out_pvalid (out_ch.peak_valid),
	.out_last   (out_ch.last_peak)
);

`default_nettype wire
